### rtl/disparity_to_3d_reprojection_top_assert.svh
// assertion macros for the disparity reprojection top level
// expects clk and rst in scope at the point of use
`ifndef DISPARITY_TO_3D_REPROJECTION_TOP_ASSERT_SVH
`define DISPARITY_TO_3D_REPROJECTION_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTR_ASSERT(lbl, prop, msg)
`define DTR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### rtl/dtr_pkg.sv
// constants, types and reset values for the disparity reprojection block
// no dependencies
`default_nettype none
package dtr_pkg;
  localparam int COORD_BITS = 12;
  localparam int DISP_W     = 16;
  localparam int COEF_W     = 32;
  localparam int FRAC_OUT   = 16;
  localparam int OUT_W      = 32;
  localparam int QUO_W      = 2 * FRAC_OUT;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = REG_IDX_W + 1;
  localparam int CFG_DATA_W = 2 * COEF_W;
  localparam int OP_W       = (COORD_BITS + 5 > DISP_W + 1) ? COORD_BITS + 5 : DISP_W + 1;
  localparam int PROD_W     = COEF_W + OP_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int DIV_STEPS  = QUO_W;
  localparam int MM_LAT     = 4;
  localparam int DIV_LAT    = DIV_STEPS + 3;
  localparam int LAT        = MM_LAT + DIV_LAT;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [3:0][3:0] coef_mat_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [3:0] sum_vec_t;
  typedef logic signed [OUT_W-1:0] point_t;
  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  localparam point_t SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam point_t SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };
endpackage
`default_nettype wire

### rtl/dtr_if.sv
// channel interfaces: pixel input, point output, configuration write
// depends on dtr_pkg
`default_nettype none
interface dtr_pix_if;
  logic                                valid;
  logic                                ready;
  logic [dtr_pkg::COORD_BITS-1:0]      pixel_col;
  logic [dtr_pkg::COORD_BITS-1:0]      pixel_row;
  logic signed [dtr_pkg::DISP_W-1:0]   disparity;
  modport source (output valid, pixel_col, pixel_row, disparity, input ready);
  modport sink (input valid, pixel_col, pixel_row, disparity, output ready);
endinterface

interface dtr_pt_if;
  logic                              valid;
  logic                              ready;
  logic signed [dtr_pkg::OUT_W-1:0]  point_x;
  logic signed [dtr_pkg::OUT_W-1:0]  point_y;
  logic signed [dtr_pkg::OUT_W-1:0]  point_z;
  logic                              divide_by_zero;
  modport source (output valid, point_x, point_y, point_z, divide_by_zero, input ready);
  modport sink (input valid, point_x, point_y, point_z, divide_by_zero, output ready);
endinterface

interface dtr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dtr_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [dtr_pkg::CFG_DATA_W-1:0]    wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

### rtl/dtr_cfg.sv
// matrix register file, unpacks the eight words into 4x4 coefficients
// depends on dtr_pkg and dtr_if
`default_nettype none
module dtr_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  dtr_cfg_if.sink             cfg,
  output dtr_pkg::coef_mat_t  coef
);
  import dtr_pkg::*;

  cfg_word_t qreg [NUM_REGS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) qreg[i] <= CFG_RESET[i];
    end else if (cfg.valid && cfg.ready && (cfg.reg_index < CFG_IDX_W'(NUM_REGS))) begin
      qreg[cfg.reg_index[REG_IDX_W-1:0]] <= cfg.wdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = (c % 2 == 0) ? qreg[r*2 + c/2][CFG_DATA_W-1:COEF_W]
                                  : qreg[r*2 + c/2][COEF_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

### rtl/dtr_matmul.sv
// four-stage matrix by (x, y, d, 1) product, 20 fraction bit row sums
// depends on dtr_pkg
`default_nettype none
module dtr_matmul (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire dtr_pkg::coef_mat_t                coef,
  input  wire logic [dtr_pkg::COORD_BITS-1:0]    col,
  input  wire logic [dtr_pkg::COORD_BITS-1:0]    row,
  input  wire logic signed [dtr_pkg::DISP_W-1:0] disp,
  output dtr_pkg::sum_vec_t                      rsum
);
  import dtr_pkg::*;

  logic signed [OP_W-1:0]   op   [4];
  logic signed [PROD_W-1:0] prod [4][4];
  sum_t                     pair [4][2];

  always_ff @(posedge clk) begin
    if (en) begin
      op[0] <= {{(OP_W-COORD_BITS-4){1'b0}}, col, 4'b0};
      op[1] <= {{(OP_W-COORD_BITS-4){1'b0}}, row, 4'b0};
      op[2] <= {{(OP_W-DISP_W){disp[DISP_W-1]}}, disp};
      op[3] <= OP_W'(16);
      for (int r = 0; r < 4; r++) begin
        for (int t = 0; t < 4; t++) prod[r][t] <= coef[r][t] * op[t];
        pair[r][0] <= sum_t'(prod[r][0]) + sum_t'(prod[r][1]);
        pair[r][1] <= sum_t'(prod[r][2]) + sum_t'(prod[r][3]);
        rsum[r]    <= pair[r][0] + pair[r][1];
      end
    end
  end
endmodule
`default_nettype wire

### rtl/dtr_div.sv
// pipelined restoring divider, one quotient bit per stage, Q16.16 saturated
// depends on dtr_pkg
`default_nettype none
module dtr_div (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire dtr_pkg::sum_t num,
  input  wire dtr_pkg::sum_t den,
  output dtr_pkg::point_t    quo
);
  import dtr_pkg::*;

  logic [SUM_W-1:0] a;
  logic [SUM_W-1:0] b;
  logic             neg;
  logic [SUM_W-1:0] rem  [DIV_STEPS+1];
  logic [SUM_W-1:0] bq   [DIV_STEPS+1];
  logic [QUO_W-1:0] low  [DIV_STEPS+1];
  logic [QUO_W-1:0] q    [DIV_STEPS+1];
  logic             negq [DIV_STEPS+1];
  logic             ovf  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      a   <= num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
      b   <= den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
      neg <= num[SUM_W-1] ^ den[SUM_W-1];
      ovf[0]  <= {{FRAC_OUT{1'b0}}, a} >= {b, {FRAC_OUT{1'b0}}};
      rem[0]  <= {{FRAC_OUT{1'b0}}, a[SUM_W-1:FRAC_OUT]};
      low[0]  <= {a[FRAC_OUT-1:0], {FRAC_OUT{1'b0}}};
      q[0]    <= '0;
      bq[0]   <= b;
      negq[0] <= neg;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [SUM_W:0] trial;
    logic [SUM_W:0] diff;
    logic           fits;
    assign trial = {rem[k], low[k][QUO_W-1]};
    assign diff  = trial - {1'b0, bq[k]};
    assign fits  = trial >= {1'b0, bq[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        q[k+1]    <= {q[k][QUO_W-2:0], fits};
        low[k+1]  <= {low[k][QUO_W-2:0], 1'b0};
        bq[k+1]   <= bq[k];
        negq[k+1] <= negq[k];
        ovf[k+1]  <= ovf[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf[DIV_STEPS]) begin
        quo <= negq[DIV_STEPS] ? SAT_NEG : SAT_POS;
      end else if (negq[DIV_STEPS]) begin
        quo <= (q[DIV_STEPS] > {1'b1, {(QUO_W-1){1'b0}}}) ? SAT_NEG
                                                            : point_t'(-q[DIV_STEPS]);
      end else begin
        quo <= q[DIV_STEPS][QUO_W-1] ? SAT_POS : point_t'(q[DIV_STEPS]);
      end
    end
  end
endmodule
`default_nettype wire

### rtl/disparity_to_3d_reprojection_top.sv
// channel  | role   | contents
// cfg      | sink   | reg_index, wdata (64-bit matrix word pair)
// pix      | sink   | pixel_col, pixel_row, disparity
// pt       | source | point_x, point_y, point_z, divide_by_zero
// one transaction per cycle while pt is not stalled; the matrix product feeds
// the divider, which resolves one quotient bit per stage
// rst clears the valid chain and loads the identity matrix
// a stall on pt freezes the whole pipeline; cfg is always ready
`default_nettype none
`include "disparity_to_3d_reprojection_top_assert.svh"
module disparity_to_3d_reprojection_top (
  input wire logic clk,
  input wire logic rst,
  dtr_cfg_if.sink  cfg,
  dtr_pix_if.sink  pix,
  dtr_pt_if.source pt
);
  import dtr_pkg::*;

  coef_mat_t coef;
  sum_vec_t  rsum;
  point_t    quo [3];
  logic      en;
  logic      vld [LAT];
  logic      dz  [DIV_LAT];

  assign en        = !vld[LAT-1] || pt.ready;
  assign pix.ready = en;

  dtr_cfg u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .coef(coef));

  dtr_matmul u_mm (
    .clk(clk), .en(en), .coef(coef), .col(pix.pixel_col), .row(pix.pixel_row),
    .disp(pix.disparity), .rsum(rsum)
  );

  for (genvar r = 0; r < 3; r++) begin : g_div
    dtr_div u_div (.clk(clk), .en(en), .num(rsum[r]), .den(rsum[3]), .quo(quo[r]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= pix.valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz[0] <= rsum[3] == '0;
      for (int i = 1; i < DIV_LAT; i++) dz[i] <= dz[i-1];
    end
  end

  assign pt.valid          = vld[LAT-1];
  assign pt.point_x        = quo[0];
  assign pt.point_y        = quo[1];
  assign pt.point_z        = quo[2];
  assign pt.divide_by_zero = dz[DIV_LAT-1];

  `DTR_ASSERT_RST(a_rst_empty, rst |=> !pt.valid, "output valid after reset")
  `DTR_ASSERT(a_enter, pix.valid && pix.ready |=> vld[0], "accepted pixel not in pipeline")
  `DTR_ASSERT(a_freeze, !en |=> $stable(pt.valid) && $stable(vld[0]), "pipeline moved in stall")
  `DTR_ASSERT(a_dz_sat, pt.valid && pt.divide_by_zero |-> ((pt.point_z == SAT_POS) || (pt.point_z == SAT_NEG)), "zero divisor not saturated")
endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the disparity reprojection top level: random and directed pixels,
// matrix settings through the configuration channel, scoreboard against a local model
// depends on dtr_pkg, dtr_if and the rtl
`default_nettype none
module tb;
  import dtr_pkg::*;

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic signed [15:0] disp;
  } pixel_t;

  typedef struct {
    point_t px;
    point_t py;
    point_t pz;
    logic dbz;
  } point_res_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;

  dtr_cfg_if cfg ();
  dtr_pix_if pix ();
  dtr_pt_if pt ();

  disparity_to_3d_reprojection_top dut (.clk(clk), .rst(rst), .cfg(cfg), .pix(pix), .pt(pt));

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  cfg_word_t matrix [NUM_REGS];
  pixel_t pending_pixels [$];
  point_res_t expected_points [$];
  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int received = 0;
  int dbz_seen = 0;
  int sat_seen = 0;
  bit quiet = 0;
  bit src_hold = 0;
  bit pix_taken = 0;
  int sink_hold = 0;
  int src_gap = 0;
  int sink_gap = 0;

  function automatic logic signed [63:0] matrix_coef(int r, int c);
    cfg_word_t w;
    w = matrix[r * 2 + c / 2];
    return (c % 2 == 0) ? {{32{w[63]}}, w[63:32]} : {{32{w[31]}}, w[31:0]};
  endfunction

  function automatic logic signed [63:0] row_dot(int r, longint x, longint y, longint d);
    return matrix_coef(r, 0) * x * 16 + matrix_coef(r, 1) * y * 16
         + matrix_coef(r, 2) * d + matrix_coef(r, 3) * 16;
  endfunction

  function automatic point_t q16_quotient(logic signed [63:0] num, logic signed [63:0] den);
    logic neg;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ip;
    logic [63:0] rem;
    logic [63:0] mag;
    neg = (num < 0) != (den < 0);
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    ip = a / b;
    rem = a % b;
    if (ip > 64'h10000) return neg ? SAT_NEG : SAT_POS;
    mag = ip;
    for (int i = 0; i < FRAC_OUT; i++) begin
      rem = rem << 1;
      mag = mag << 1;
      if (rem >= b) begin
        rem = rem - b;
        mag[0] = 1'b1;
      end
    end
    if (neg) return (mag > 64'h8000_0000) ? SAT_NEG : point_t'(-mag);
    return (mag > 64'h7FFF_FFFF) ? SAT_POS : point_t'(mag);
  endfunction

  function automatic point_res_t reproject(pixel_t p);
    point_res_t res;
    logic signed [63:0] w;
    logic signed [63:0] n [3];
    point_t v [3];
    w = row_dot(3, p.col, p.row, p.disp);
    for (int r = 0; r < 3; r++) begin
      n[r] = row_dot(r, p.col, p.row, p.disp);
      if (w == 0) v[r] = (n[r] < 0) ? SAT_NEG : SAT_POS;
      else v[r] = q16_quotient(n[r], w);
    end
    res.px = v[0];
    res.py = v[1];
    res.pz = v[2];
    res.dbz = (w == 0);
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on %s at result %0d: got %h, expected %h", what, received, got, want);
  endtask

  // pixel driver
  initial begin
    pix.valid = 0;
    pix.pixel_col = 0;
    pix.pixel_row = 0;
    pix.disparity = 0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!(pix.valid && !pix_taken)) begin
        if (!quiet && src_gap == 0 && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 8);
        if (src_gap > 0) src_gap--;
        if (pending_pixels.size() > 0 && !src_hold && (src_gap == 0 || quiet)) begin
          pix.valid <= 1;
          pix.pixel_col <= pending_pixels[0].col;
          pix.pixel_row <= pending_pixels[0].row;
          pix.disparity <= pending_pixels[0].disp;
        end else begin
          pix.valid <= 0;
        end
      end
    end
  end

  // expected points are formed on acceptance
  always @(posedge clk) begin
    pix_taken = !rst && pix.valid && pix.ready;
    if (pix_taken) begin
      pixel_t p;
      p.col = pix.pixel_col;
      p.row = pix.pixel_row;
      p.disp = pix.disparity;
      expected_points.insert(expected_points.size(), reproject(p));
      void'(pending_pixels.pop_front());
      accepted++;
    end
  end

  // point receiver ready
  initial pt.ready = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (sink_hold > 0) begin
        sink_hold--;
        pt.ready <= 0;
      end else begin
        if (!quiet && sink_gap == 0 && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 8);
        if (sink_gap > 0) sink_gap--;
        pt.ready <= quiet || sink_gap == 0;
      end
    end
  end

  // point monitor
  always @(posedge clk) begin
    cycles++;
    if (!rst && pt.valid && pt.ready) begin
      point_res_t e;
      if (expected_points.size() == 0) begin
        report("unexpected point transaction", pt.point_x, 32'h0);
      end else begin
        e = expected_points.pop_front();
        if (pt.point_x !== e.px) report("point_x", pt.point_x, e.px);
        if (pt.point_y !== e.py) report("point_y", pt.point_y, e.py);
        if (pt.point_z !== e.pz) report("point_z", pt.point_z, e.pz);
        if (pt.divide_by_zero !== e.dbz) report("divide_by_zero", pt.divide_by_zero, e.dbz);
        if (e.dbz) dbz_seen++;
        if (e.px == SAT_POS || e.px == SAT_NEG) sat_seen++;
      end
      received++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cfg.valid = 0;
    cfg.reg_index = 0;
    cfg.wdata = 0;
  end

  task automatic write_reg(int idx, cfg_word_t val);
    @(negedge clk);
    cfg.valid <= 1;
    cfg.reg_index <= idx[CFG_IDX_W-1:0];
    cfg.wdata <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx < NUM_REGS) matrix[idx] = val;
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || expected_points.size() > 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef(int kind);
    case (kind)
      0: return $urandom_range(0, 7) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return $urandom;
      2: return {{14{1'b0}}, 18'($urandom)} ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 0);
      default: return 0;
    endcase
  endfunction

  task automatic load_matrix(int kind);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(i, {rand_coef(kind), rand_coef(kind)});
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.col = $urandom;
    p.row = $urandom;
    p.disp = $urandom;
    return p;
  endfunction

  task automatic push_pixels(int n);
    for (int i = 0; i < n; i++) pending_pixels.insert(pending_pixels.size(), rand_pixel());
  endtask

  initial begin
    pixel_t p;
    for (int i = 0; i < NUM_REGS; i++) matrix[i] = CFG_RESET[i];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed pixels through the identity matrix
    for (int c = 0; c < 2; c++)
      for (int r = 0; r < 2; r++)
        for (int d = 0; d < 4; d++) begin
          p.col = c ? 12'hFFF : 12'h000;
          p.row = r ? 12'hFFF : 12'h000;
          case (d)
            0: p.disp = 16'sh7FFF;
            1: p.disp = -16'sh8000;
            2: p.disp = 0;
            default: p.disp = 16'sh0001;
          endcase
          pending_pixels.insert(pending_pixels.size(), p);
        end
    drain();

    // zero divisor: last row cleared, then negative numerators too
    write_reg(7, 64'h0);
    write_reg(0, 64'hFFFF_0000_0001_0000);
    write_reg(8, 64'hDEAD_BEEF_DEAD_BEEF);
    push_pixels(6);
    drain();

    // divisor w = disparity
    write_reg(6, 64'h0);
    write_reg(7, 64'h0001_0000_0000_0000);
    push_pixels(8);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      load_matrix(phase % 3);
      if (phase == 3) write_reg(6, 64'h0);
      if (phase == 3) write_reg(7, {32'h0000_0001, 32'h0000_0000});
      if (phase == 2) begin
        // long receiver stall while pixels keep coming
        push_pixels(20);
        sink_hold = 150;
        push_pixels(80);
      end else begin
        push_pixels(100);
      end
      drain();
    end

    // pause the sender with pixels pending, then release it
    src_hold = 1;
    push_pixels(10);
    repeat (20) @(posedge clk);
    src_hold = 0;
    drain();

    for (int i = 0; i < NUM_REGS; i++) write_reg(i, CFG_RESET[i]);
    quiet = 1;
    push_pixels(60);
    drain();

    $display("%0d pixels in, %0d points out, %0d with zero divisor, %0d saturated in x",
             accepted, received, dbz_seen, sat_seen);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
